// ----- sv/erfo_pkg.sv -----
// ----------------------------------------------------------------------------
// erfo_pkg - shared types and constants for the event ring queue
// queue depth, entry and request/response structs, status codes
// ----------------------------------------------------------------------------
package erfo_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int WORD_W      = 32;

	// request kinds
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// response status codes
	localparam logic [2:0] ST_STORED       = 3'd0;
	localparam logic [2:0] ST_OVERWROTE    = 3'd1;
	localparam logic [2:0] ST_NULL_HANDLER = 3'd2;
	localparam logic [2:0] ST_FULL_REFUSED = 3'd3;
	localparam logic [2:0] ST_POPPED       = 3'd4;
	localparam logic [2:0] ST_EMPTY        = 3'd5;

	typedef struct packed {
		logic              req_type;
		logic              overwrite_oldest;
		logic [WORD_W-1:0] handler_word;
		logic [WORD_W-1:0] argument_word;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [WORD_W-1:0] popped_handler;
		logic [WORD_W-1:0] popped_argument;
		logic [CNT_W-1:0]  free_space;
	} rsp_t;

	typedef struct packed {
		logic [WORD_W-1:0] handler;
		logic [WORD_W-1:0] argument;
	} entry_t;

	// controls from erfo_ctrl to the row of cells
	typedef struct packed {
		logic                   shift;
		logic [QUEUE_DEPTH-1:0] load;
	} cell_ctl_t;

endpackage

// ----- sv/erfo_cell.sv -----
// ----------------------------------------------------------------------------
// erfo_cell - one queue slot
// holds one entry; loads a new entry or takes its upper neighbor's entry
// ----------------------------------------------------------------------------
module erfo_cell
	import erfo_pkg::*;
(
	input  logic   clk,
	input  logic   shift,
	input  logic   load,
	input  entry_t next_entry,
	input  entry_t new_entry,
	output entry_t entry
);

	entry_t entry_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= new_entry;
		end else if (shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

// ----- sv/erfo_ctrl.sv -----
// ----------------------------------------------------------------------------
// erfo_ctrl - occupancy tracking and request decode
// decides per request what the cells do and builds the response
// ----------------------------------------------------------------------------
module erfo_ctrl
	import erfo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  req_t      req,
	input  entry_t    head,
	output cell_ctl_t ctl,
	output rsp_t      rsp
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nx;
	logic             full;
	logic             empty;
	logic             shift;
	logic             ld_en;
	logic [IDX_W-1:0] ld_idx;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		count_nx            = count_q;
		shift               = 1'b0;
		ld_en               = 1'b0;
		ld_idx              = count_q[IDX_W-1:0];
		rsp.status          = ST_STORED;
		rsp.popped_handler  = '0;
		rsp.popped_argument = '0;
		if (req.req_type == REQ_POP) begin
			if (empty) begin
				rsp.status = ST_EMPTY;
			end else begin
				rsp.status          = ST_POPPED;
				rsp.popped_handler  = head.handler;
				rsp.popped_argument = head.argument;
				shift               = 1'b1;
				count_nx            = count_q - CNT_W'(1);
			end
		end else if (req.handler_word == '0) begin
			rsp.status = ST_NULL_HANDLER;
		end else if (full) begin
			if (req.overwrite_oldest) begin
				// drop the oldest, new entry lands in the top cell
				rsp.status = ST_OVERWROTE;
				shift      = 1'b1;
				ld_en      = 1'b1;
				ld_idx     = IDX_W'(QUEUE_DEPTH - 1);
			end else begin
				rsp.status = ST_FULL_REFUSED;
			end
		end else begin
			ld_en    = 1'b1;
			count_nx = count_q + CNT_W'(1);
		end
		rsp.free_space = CNT_W'(QUEUE_DEPTH) - count_nx;
	end

	always_comb begin
		ctl.shift = accept & shift;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ctl.load[i] = accept & ld_en & (ld_idx == IDX_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nx;
		end
	end

endmodule

// ----- sv/erfo_outbuf.sv -----
// ----------------------------------------------------------------------------
// erfo_outbuf - response register with skid slot
// keeps the request side open while one response waits downstream
// ----------------------------------------------------------------------------
module erfo_outbuf
	import erfo_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rsp_t din,
	input  logic out_stall,
	output logic out_valid,
	output rsp_t dout,
	output logic busy
);

	logic out_valid_q;
	logic skid_valid_q;
	rsp_t out_q;
	rsp_t skid_q;
	logic take;
	logic open;

	assign take = out_valid_q & ~out_stall;
	assign open = ~out_valid_q | take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (open) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (open) begin
			out_q <= skid_valid_q ? skid_q : din;
		end
		if (!open && push) begin
			skid_q <= din;
		end
	end

	assign out_valid = out_valid_q;
	assign dout      = out_q;
	assign busy      = skid_valid_q;

endmodule

// ----- sv/event_ring_fifo_overwrite_top.sv -----
// ----------------------------------------------------------------------------
// event_ring_fifo_overwrite_top - event queue with optional overwrite
// queue of handler/argument entries held in a row of shifting cells
// ----------------------------------------------------------------------------
// One request is taken per clock while req_stall is low; its response is
// registered before it shows up on rsp, and every request yields exactly
// one response. The entries sit in a row of QUEUE_DEPTH cells ordered by
// age, the oldest in cell 0: a push loads the first free cell, a pop (or a
// push over the oldest entry on a full queue) moves every cell down by one
// in the same cycle, so there is no read pointer and no memory port to wait
// on. The response register has a skid slot behind it, so req_stall only
// rises once two responses are waiting unread. Nothing needs to be cleared
// after reset: the queue starts empty and cells are only read once written.
// ----------------------------------------------------------------------------
module event_ring_fifo_overwrite_top
	import erfo_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	// request channel
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	// response channel
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic      accept;
	logic      busy;
	cell_ctl_t ctl;
	rsp_t      rsp_nx;
	entry_t    new_entry;
	entry_t    cell_entry [QUEUE_DEPTH];

	// request taken whenever the skid slot is free
	assign req_stall = busy;
	assign accept    = req_valid & ~busy;

	assign new_entry.handler  = req.handler_word;
	assign new_entry.argument = req.argument_word;

	// occupancy and per-request decisions
	erfo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.head   (cell_entry[0]),
		.ctl    (ctl),
		.rsp    (rsp_nx)
	);

	// row of cells, each one fed from its upper neighbor
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t next_entry;
		if (i == QUEUE_DEPTH - 1) begin : g_top
			assign next_entry = '0;
		end else begin : g_mid
			assign next_entry = cell_entry[i + 1];
		end
		erfo_cell u_cell (
			.clk        (clk),
			.shift      (ctl.shift),
			.load       (ctl.load[i]),
			.next_entry (next_entry),
			.new_entry  (new_entry),
			.entry      (cell_entry[i])
		);
	end

	// response register plus skid slot
	erfo_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (rsp_nx),
		.out_stall (rsp_stall),
		.out_valid (rsp_valid),
		.dout      (rsp),
		.busy      (busy)
	);

endmodule

// ----- tb/sv/event_ring_fifo_overwrite_top_test.sv -----
// ----------------------------------------------------------------------------
// event_ring_fifo_overwrite_top_test - self-checking bench for the event queue
// pushes and pops go in through a valid/stall channel and each response is
// checked against a ring queue model with its own pointers and entry store
// ----------------------------------------------------------------------------
module event_ring_fifo_overwrite_top_test;
	import erfo_pkg::*;

	// generous bound on the whole run, far above the slowest legal run
	localparam int RUN_LIMIT       = 200000;
	// length of the long response hold-off, in cycles
	localparam int RSP_HOLD_CYCLES = 80;

	// every block input starts at a known value
	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	event_ring_fifo_overwrite_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ring queue model: positions count modulo twice the depth, so full and
	// empty differ by the extra top bit
	logic [IDX_W:0]    write_pos = '0;
	logic [IDX_W:0]    read_pos  = '0;
	logic [WORD_W-1:0] handler_mem  [QUEUE_DEPTH];
	logic [WORD_W-1:0] argument_mem [QUEUE_DEPTH];

	// responses owed by the block, oldest first
	rsp_t pending_responses [$];

	int fail_count  = 0;
	int cycle_count = 0;

	// idling switches for the sender and the receiver
	bit req_idle_en = 1'b1;
	bit rsp_idle_en = 1'b1;
	bit rsp_hold_go = 1'b0;

	// advance the queue model by one request and return its response
	function automatic rsp_t next_queue_response(input req_t r);
		rsp_t           res;
		logic [IDX_W:0] fill;
		res  = '0;
		fill = write_pos - read_pos;
		if (r.req_type == REQ_POP) begin
			if (fill == '0) begin
				res.status = ST_EMPTY;
			end else begin
				res.status          = ST_POPPED;
				res.popped_handler  = handler_mem[read_pos[IDX_W-1:0]];
				res.popped_argument = argument_mem[read_pos[IDX_W-1:0]];
				read_pos            = read_pos + (IDX_W+1)'(1);
			end
		end else if (r.handler_word == '0) begin
			// null handler: nothing moves, even on a full queue
			res.status = ST_NULL_HANDLER;
		end else if (fill == (IDX_W+1)'(QUEUE_DEPTH) && !r.overwrite_oldest) begin
			res.status = ST_FULL_REFUSED;
		end else begin
			res.status = ST_STORED;
			if (fill == (IDX_W+1)'(QUEUE_DEPTH)) begin
				// drop the oldest entry to make room
				res.status = ST_OVERWROTE;
				read_pos   = read_pos + (IDX_W+1)'(1);
			end
			handler_mem[write_pos[IDX_W-1:0]]  = r.handler_word;
			argument_mem[write_pos[IDX_W-1:0]] = r.argument_word;
			write_pos = write_pos + (IDX_W+1)'(1);
		end
		fill           = write_pos - read_pos;
		res.free_space = CNT_W'(QUEUE_DEPTH - int'(fill));
		return res;
	endfunction

	// mostly no gap, often a short one, now and then a long one
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// data words lean on the extremes now and then
	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t make_request(input logic kind, input logic ovw,
			input logic [WORD_W-1:0] handler, input logic [WORD_W-1:0] argument);
		req_t r;
		r.req_type         = kind;
		r.overwrite_oldest = ovw;
		r.handler_word     = handler;
		r.argument_word    = argument;
		return r;
	endfunction

	// push fields are random on pops too, where the block must ignore them
	function automatic req_t random_request(input int push_pct);
		return make_request(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP,
			1'($urandom_range(0, 1)), random_word(), random_word());
	endfunction

	// offer one request, hold it until taken, then log what it should return
	task automatic send_request(input req_t r);
		int gap;
		gap = req_idle_en ? idle_length() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		pending_responses.push_back(next_queue_response(r));
	endtask

	// stop sending and let every owed response come back
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		// margin past the response register and the skid slot
		repeat (4) @(posedge clk);
	endtask

	function automatic void check_field(input string name,
			input logic [WORD_W-1:0] want, input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// receiver: random stall runs, or a long counted hold-off when asked
	int rsp_hold_left = 0;
	int rsp_run_left  = 0;
	bit rsp_stalling  = 1'b0;

	always @(posedge clk) begin
		if (rsp_hold_go) begin
			rsp_hold_go   = 1'b0;
			rsp_hold_left = RSP_HOLD_CYCLES;
		end
		if (rsp_hold_left > 0) begin
			rsp_hold_left--;
			rsp_stall <= 1'b1;
		end else if (!rsp_idle_en) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_run_left == 0) begin
				rsp_stalling = ($urandom_range(0, 2) == 0);
				rsp_run_left = rsp_stalling ? idle_length() + 1 : $urandom_range(1, 10);
			end
			rsp_run_left--;
			rsp_stall <= rsp_stalling;
		end
	end

	// response checker: every taken response against the oldest owed one
	always @(posedge clk) begin : check_responses
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: response with no request outstanding, expected none actual %h",
					$time, rsp);
				fail_count++;
			end else begin
				want = pending_responses.pop_front();
				check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
				check_field("popped_handler", want.popped_handler, rsp.popped_handler);
				check_field("popped_argument", want.popped_argument, rsp.popped_argument);
				check_field("free_space", WORD_W'(want.free_space), WORD_W'(rsp.free_space));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("event_ring_fifo_overwrite_top regression: fail");
			$finish;
		end
	end

	// corner cases: empty pop, null handler, extreme words, fill to full,
	// refused and overwriting pushes, null handler on a full queue
	task automatic test_directed();
		// pop of an empty queue with all push fields set
		send_request(make_request(REQ_POP, 1'b1, '1, '1));
		// null handler is rejected
		send_request(make_request(REQ_PUSH, 1'b1, '0, '1));
		send_request(make_request(REQ_PUSH, 1'b0, '1, '0));
		// overwrite flag has no effect when the queue is not full
		send_request(make_request(REQ_PUSH, 1'b1, 32'h0000_0001, '1));
		send_request(make_request(REQ_POP, 1'b0, '0, '0));
		// one entry left, fill the rest
		for (int i = 0; i < QUEUE_DEPTH - 1; i++)
			send_request(make_request(REQ_PUSH, 1'b0, $urandom | 32'h1, $urandom));
		// full: refused, then stored over the oldest
		send_request(make_request(REQ_PUSH, 1'b0, 32'h8000_0000, 32'h5555_5555));
		send_request(make_request(REQ_PUSH, 1'b1, 32'hA5A5_A5A5, 32'hAAAA_AAAA));
		// null handler wins over the full check
		send_request(make_request(REQ_PUSH, 1'b1, '0, 32'h1234_5678));
		send_request(make_request(REQ_POP, 1'b1, '1, '1));
		send_request(make_request(REQ_PUSH, 1'b1, 32'h7FFF_FFFF, 32'h8000_0001));
		wait_for_drain();
	endtask

	// random traffic in phases of push-heavy and pop-heavy mixes, so the
	// queue swings between empty and full and wraps many times
	task automatic test_random_traffic(input int count);
		int push_pct;
		push_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 3))
					0: push_pct = 20;
					1: push_pct = 50;
					2: push_pct = 75;
					default: push_pct = 95;
				endcase
			end
			// sender pauses midway until every response is back
			if (i == count / 2)
				wait_for_drain();
			send_request(random_request(push_pct));
		end
		wait_for_drain();
	endtask

	// receiver holds off for a long stretch while requests keep coming,
	// so the response path fills and the block stalls its input
	task automatic test_backpressure(input int count);
		req_idle_en = 1'b0;
		rsp_hold_go = 1'b1;
		for (int i = 0; i < count; i++)
			send_request(random_request(70));
		req_idle_en = 1'b1;
		wait_for_drain();
	endtask

	// back-to-back requests with no stall on either side
	task automatic test_streaming(input int count);
		req_idle_en = 1'b0;
		rsp_idle_en = 1'b0;
		for (int i = 0; i < count; i++)
			send_request(random_request(60));
		wait_for_drain();
		req_idle_en = 1'b1;
		rsp_idle_en = 1'b1;
	endtask

	initial begin
		// reset held low at the start, released once
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_traffic(600);
		test_backpressure(50);
		test_streaming(120);
		if (fail_count == 0) begin
			$display("event_ring_fifo_overwrite_top regression: pass");
		end else begin
			$display("event_ring_fifo_overwrite_top regression: fail");
		end
		$finish;
	end

endmodule
